>>> rtl/core/bsu_pkg.sv
// ----------------------------------------------------------------------------
// bsu_pkg
// Shared constants, types and helpers of the 8080 branch and stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsu_pkg;

    // Stack memory geometry: two byte-wide banks, even and odd addresses
    localparam int MEM_BYTES  = 65536;
    localparam int MEM_AW     = $clog2(MEM_BYTES);
    localparam int BANK_AW    = MEM_AW - 1;
    localparam int BANK_DEPTH = MEM_BYTES / 2;

    // Stream widths
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;

    // Action codes
    localparam logic [2:0] ACT_JUMP   = 3'd0;
    localparam logic [2:0] ACT_CALL   = 3'd1;
    localparam logic [2:0] ACT_RET    = 3'd2;
    localparam logic [2:0] ACT_PCHL   = 3'd3;
    localparam logic [2:0] ACT_SET_SP = 3'd4;

    // Condition codes; unused codes behave as always
    localparam logic [3:0] COND_ALWAYS = 4'd0;
    localparam logic [3:0] COND_NZ     = 4'd1;
    localparam logic [3:0] COND_Z      = 4'd2;
    localparam logic [3:0] COND_NC     = 4'd3;
    localparam logic [3:0] COND_C      = 4'd4;
    localparam logic [3:0] COND_PO     = 4'd5;
    localparam logic [3:0] COND_PE     = 4'd6;
    localparam logic [3:0] COND_P      = 4'd7;
    localparam logic [3:0] COND_M      = 4'd8;

    // Decoded operation of one instruction
    typedef struct packed {
        logic taken;      // transfer happens
        logic pc_target;  // PC <- target word
        logic pc_hl;      // PC <- HL
        logic push;       // write PC to stack, SP -= 2
        logic pop;        // read PC from stack, SP += 2
        logic sp_load;    // SP <- target word
    } t_dec;

    // Condition test against the flags
    function automatic logic cond_holds(input logic [3:0] cond, input logic z,
                                        input logic c, input logic p,
                                        input logic s);
        logic ok;
        case (cond)
            COND_NZ: ok = !z;
            COND_Z:  ok = z;
            COND_NC: ok = !c;
            COND_C:  ok = c;
            COND_PO: ok = !p;
            COND_PE: ok = p;
            COND_P:  ok = !s;
            COND_M:  ok = s;
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bsu_decode.sv
// ----------------------------------------------------------------------------
// bsu_decode
// Tests the condition and turns action plus result into register operations.
// ----------------------------------------------------------------------------
`default_nettype none

module bsu_decode (
    input  wire logic [2:0] i_action,
    input  wire logic [3:0] i_condition,
    input  wire logic       i_zero_flag,
    input  wire logic       i_carry_flag,
    input  wire logic       i_parity_flag,
    input  wire logic       i_sign_flag,
    output bsu_pkg::t_dec   o_dec
);

    logic ok;

    assign ok = bsu_pkg::cond_holds(i_condition, i_zero_flag, i_carry_flag,
                                    i_parity_flag, i_sign_flag);

    // Action decoder; unused action codes change nothing
    always_comb begin
        o_dec = '0;
        unique case (i_action)
            bsu_pkg::ACT_JUMP: begin
                o_dec.taken     = ok;
                o_dec.pc_target = ok;
            end
            bsu_pkg::ACT_CALL: begin
                o_dec.taken     = ok;
                o_dec.pc_target = ok;
                o_dec.push      = ok;
            end
            bsu_pkg::ACT_RET: begin
                o_dec.taken = ok;
                o_dec.pop   = ok;
            end
            bsu_pkg::ACT_PCHL: begin
                o_dec.taken = 1'b1;
                o_dec.pc_hl = 1'b1;
            end
            bsu_pkg::ACT_SET_SP: begin
                o_dec.taken   = 1'b1;
                o_dec.sp_load = 1'b1;
            end
            default: o_dec = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/bsu_stack_ram.sv
// ----------------------------------------------------------------------------
// bsu_stack_ram
// Byte stack split into even and odd banks, so a 16-bit push or pop at any
// byte address is a single access. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsu_stack_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic                       i_we,
    input  wire logic [bsu_pkg::MEM_AW-1:0] i_base,   // address of the low byte
    input  wire logic [15:0]                i_wdata,  // {high byte, low byte}
    output logic [15:0]                     o_rdata   // {high byte, low byte}
);

    logic [7:0] r_bank0 [bsu_pkg::BANK_DEPTH];
    logic [7:0] r_bank1 [bsu_pkg::BANK_DEPTH];
    logic [7:0] r_rd0;
    logic [7:0] r_rd1;
    logic       r_odd;

    logic                        odd;
    logic [bsu_pkg::MEM_AW-1:0]  base_p1;
    logic [bsu_pkg::BANK_AW-1:0] addr0;
    logic [bsu_pkg::BANK_AW-1:0] addr1;
    logic [7:0]                  wd0;
    logic [7:0]                  wd1;

    // Low byte at base, high byte at base+1 (wraps over the memory)
    always_comb begin
        odd     = i_base[0];
        base_p1 = i_base + {{(bsu_pkg::MEM_AW-1){1'b0}}, 1'b1};
        addr1   = i_base[bsu_pkg::MEM_AW-1:1];
        addr0   = odd ? base_p1[bsu_pkg::MEM_AW-1:1] : i_base[bsu_pkg::MEM_AW-1:1];
        wd0     = odd ? i_wdata[15:8] : i_wdata[7:0];
        wd1     = odd ? i_wdata[7:0]  : i_wdata[15:8];
    end

    // Banks: write both bytes or read both bytes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_bank0[addr0] <= wd0;
                r_bank1[addr1] <= wd1;
            end else begin
                r_rd0 <= r_bank0[addr0];
                r_rd1 <= r_bank1[addr1];
                r_odd <= odd;
            end
        end
    end

    assign o_rdata = r_odd ? {r_rd0, r_rd1} : {r_rd1, r_rd0};

endmodule

`default_nettype wire

>>> rtl/core/cpu8080_branch_stack_unit_top.sv
// ----------------------------------------------------------------------------
// cpu8080_branch_stack_unit_top
// Jump / call / return / PCHL / set-SP unit with PC, SP and a byte stack.
//
// Channel   Dir  tdata (low bit up)                             tuser
// s_axis    in   condition, target_word, hl_value, z, c, p, s   action
// m_axis    out  new_pc, new_sp, taken, zero pad                -
//
// One instruction word is accepted per cycle while s_axis_tready is high; it
// is held in the stage register and moves to the output register when the
// output is free. A taken call or return makes one access to the stack
// banks; a return's PC comes from the bank read data and is forwarded to the
// next word. Reset clears PC, SP and the pipeline; stack contents are not
// cleared. A stall on m_axis holds the pipeline word, and s_axis_tready drops
// only while the stage and output words are both full and m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu8080_branch_stack_unit_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] condition, [19:4] target_word, [35:20] hl_value,
    // [36] zero_flag, [37] carry_flag, [38] parity_flag, [39] sign_flag
    input  wire logic [bsu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] action
    input  wire logic [bsu_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [15:0] new_pc, [31:16] new_sp, [32] taken, [39:33] zero
    output logic [bsu_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    logic [3:0]     in_cond;
    logic [15:0]    in_target;
    logic [15:0]    in_hl;
    bsu_pkg::t_dec  dec;

    logic [15:0]    r_pc;
    logic [15:0]    r_sp;
    logic           r_ret_pend;
    logic [15:0]    n_pc;
    logic [15:0]    n_sp;
    logic [15:0]    eff_pc;

    logic           r_s1_valid;
    logic [15:0]    r_s1_pc;
    logic [15:0]    r_s1_sp;
    logic           r_s1_taken;
    logic           r_s1_ret;
    logic [15:0]    s1_pc;

    logic           r_m_valid;
    logic [15:0]    r_m_pc;
    logic [15:0]    r_m_sp;
    logic           r_m_taken;

    logic           accept;
    logic           out_free;
    logic           advance;

    logic           mem_en;
    logic [15:0]    mem_base;
    logic [15:0]    mem_rdata;

    assign in_cond   = s_axis_tdata[3:0];
    assign in_target = s_axis_tdata[19:4];
    assign in_hl     = s_axis_tdata[35:20];

    bsu_decode u_decode (
        .i_action      (s_axis_tuser),
        .i_condition   (in_cond),
        .i_zero_flag   (s_axis_tdata[36]),
        .i_carry_flag  (s_axis_tdata[37]),
        .i_parity_flag (s_axis_tdata[38]),
        .i_sign_flag   (s_axis_tdata[39]),
        .o_dec         (dec)
    );

    // Handshake
    assign out_free      = !r_m_valid || m_axis_tready;
    assign advance       = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // PC of the previous word, forwarded from the stack read after a return
    assign eff_pc = r_ret_pend ? mem_rdata : r_pc;

    // Stack access: push writes at SP-2/SP-1, pop reads at SP/SP+1
    assign mem_en   = accept && (dec.push || dec.pop);
    assign mem_base = dec.push ? (r_sp - 16'd2) : r_sp;

    bsu_stack_ram u_stack_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (dec.push),
        .i_base  (mem_base[bsu_pkg::MEM_AW-1:0]),
        .i_wdata (eff_pc),
        .o_rdata (mem_rdata)
    );

    // Next PC and SP
    always_comb begin
        n_pc = eff_pc;
        n_sp = r_sp;
        if (accept) begin
            if (dec.pc_target) begin
                n_pc = in_target;
            end else if (dec.pc_hl) begin
                n_pc = in_hl;
            end
            if (dec.push) begin
                n_sp = r_sp - 16'd2;
            end else if (dec.pop) begin
                n_sp = r_sp + 16'd2;
            end else if (dec.sp_load) begin
                n_sp = in_target;
            end
        end
    end

    assign s1_pc = r_s1_ret ? mem_rdata : r_s1_pc;

    // Architectural state, result stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_sp       <= '0;
            r_ret_pend <= 1'b0;
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_pc       <= n_pc;
            r_sp       <= n_sp;
            r_ret_pend <= accept && dec.pop;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pc    <= n_pc;
            r_s1_sp    <= n_sp;
            r_s1_taken <= dec.taken;
            r_s1_ret   <= dec.pop;
        end
        if (advance) begin
            r_m_pc    <= s1_pc;
            r_m_sp    <= r_s1_sp;
            r_m_taken <= r_s1_taken;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_m_taken, r_m_sp, r_m_pc};

endmodule

`default_nettype wire

>>> rtl/core/bsu_checker.sv
// ----------------------------------------------------------------------------
// bsu_checker
// Port-level checks of the branch and stack unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsu_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [bsu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [15:0] r_last_pc;
    logic [15:0] r_last_sp;
    logic        m_acc;

    assign m_acc = m_axis_tvalid && m_axis_tready;

    // PC and SP of the last delivered word (zero after reset)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pc <= '0;
            r_last_sp <= '0;
        end else if (m_acc) begin
            r_last_pc <= m_axis_tdata[15:0];
            r_last_sp <= m_axis_tdata[31:16];
        end
    end

    // No result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result word shown right after reset");

    // An empty output never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

    // A word that was not taken leaves PC and SP as the previous word left them
    a_not_taken_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && !m_axis_tdata[32]) |->
            (m_axis_tdata[15:0] == r_last_pc && m_axis_tdata[31:16] == r_last_sp))
        else $error("state changed by a word that was not taken");

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result payload changed under stall");

    // Pad bits of a result word are zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[bsu_pkg::OUT_DATA_W-1:33] == '0))
        else $error("result pad bits not zero");

endmodule

bind cpu8080_branch_stack_unit_top bsu_checker u_bsu_checker (.*);

`default_nettype wire
